### design/ghsp_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package ghsp_pkg;
  localparam int NumTables = 8;
  localparam int HistWords = 8;
  localparam int WordBits = 32;
  localparam int PathBits = 16;
  localparam int IdxW = 13;
  localparam int CtrW = 6;
  localparam int SumW = 9;
  localparam int ThrCtrW = 8;
  localparam int ThrCtrTop = 127;
  localparam int ThrCtrBot = -128;
  localparam int ClrW = 13;

  // request commands
  localparam logic CmdPredict = 1'b0;
  localparam logic CmdUpdate = 1'b1;

  typedef logic [IdxW-1:0] idx_t;
  typedef logic signed [CtrW-1:0] ctr_t;

  typedef struct packed {
    logic clear;
    logic [ClrW-1:0] clr_addr;
    logic read;
    logic sum;
    logic update;
  } cmd_t;

  function automatic int idx_bits(input int t);
    case (t)
      0: return 6;
      1: return 7;
      2: return 8;
      3: return 10;
      4: return 11;
      5: return 12;
      default: return 13;
    endcase
  endfunction

  function automatic int ctr_bits(input int t);
    return (t < 2) ? 4 : 5;
  endfunction

  // number of history words xored in; zero means use word 0 raw, negative means none
  function automatic int hist_words(input int t);
    case (t)
      0, 1: return 0;
      2, 3: return -1;
      4: return 1;
      5: return 2;
      6: return 4;
      default: return 8;
    endcase
  endfunction
endpackage
`default_nettype wire

### design/ghsp_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
module ghsp_ctrl (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_ready_o,
  input  logic command_i,
  input  logic out_busy_i,
  output ghsp_pkg::cmd_t cmd_o
);
  import ghsp_pkg::*;
  localparam logic [1:0] StClear = 2'd0;
  localparam logic [1:0] StIdle = 2'd1;
  localparam logic [1:0] StSum = 2'd2;
  logic [1:0] state_q, state_d;
  logic [ClrW-1:0] clr_q, clr_d;
  logic acc;

  assign in_ready_o = (state_q == StIdle) && !out_busy_i;
  assign acc = in_valid_i && in_ready_o;

  always_comb begin
    state_d = state_q;
    clr_d = clr_q;
    cmd_o = '0;
    cmd_o.clr_addr = clr_q;
    unique case (state_q)
      StClear: begin
        cmd_o.clear = 1'b1;
        clr_d = clr_q + 1'b1;
        if (&clr_q) state_d = StIdle;
      end
      StIdle: begin
        if (acc && command_i == CmdPredict) begin
          cmd_o.read = 1'b1;
          state_d = StSum;
        end else if (acc) begin
          cmd_o.update = 1'b1;
        end
      end
      StSum: begin
        cmd_o.sum = 1'b1;
        state_d = StIdle;
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StClear;
      clr_q <= '0;
    end else begin
      state_q <= state_d;
      clr_q <= clr_d;
    end
  end
endmodule
`default_nettype wire

### design/ghsp_datapath.sv
`timescale 1ns / 1ps
`default_nettype none
module ghsp_datapath (
  input  logic clk_i,
  input  logic rst_ni,
  input  ghsp_pkg::cmd_t cmd_i,
  input  logic [31:0] pc_i,
  input  logic actual_taken_i,
  input  logic predicted_taken_i,
  output logic out_valid_o,
  input  logic out_ready_i,
  output logic predict_taken_o,
  output logic signed [ghsp_pkg::SumW-1:0] confidence_sum_o
);
  import ghsp_pkg::*;
  logic [WordBits-1:0] ghist_q [HistWords];
  logic started_q;
  logic [PathBits-1:0] path_q;
  idx_t idx_q [NumTables];
  ctr_t rd_q [NumTables];
  logic signed [SumW-1:0] last_sum_q;
  logic signed [SumW-1:0] thr_q;
  logic signed [ThrCtrW-1:0] tctr_q;
  logic out_valid_q;
  logic signed [SumW-1:0] out_sum_q;

  idx_t hash [NumTables];
  ctr_t newc [NumTables];
  logic train, miss;
  logic signed [SumW:0] mag;
  logic signed [SumW+1:0] sum;

  always_comb begin
    logic [WordBits-1:0] acc;
    for (int t = 0; t < NumTables; t++) begin
      acc = '0;
      if (hist_words(t) == 0) acc = ghist_q[0];
      else for (int w = 0; w < HistWords; w++)
        if (w < hist_words(t)) acc = acc ^ ghist_q[w];
      hash[t] = (pc_i[IdxW-1:0] ^ acc[IdxW-1:0] ^ path_q[IdxW-1:0])
                & idx_t'((1 << idx_bits(t)) - 1);
    end
  end

  assign mag = last_sum_q[SumW-1] ? -{last_sum_q[SumW-1], last_sum_q}
                                  : {last_sum_q[SumW-1], last_sum_q};
  assign miss = predicted_taken_i != actual_taken_i;
  assign train = miss || (mag <= $signed({thr_q[SumW-1], thr_q}));

  always_comb begin
    for (int t = 0; t < NumTables; t++) begin
      newc[t] = rd_q[t];
      if (actual_taken_i) begin
        if (rd_q[t] < ctr_t'((1 << ctr_bits(t)) - 1)) newc[t] = rd_q[t] + 1'b1;
      end else if (rd_q[t] > ctr_t'(-(1 << ctr_bits(t)))) newc[t] = rd_q[t] - 1'b1;
    end
  end

  // counter memories, one per table; read at hashed index on a predict, else at stored index
  // a trained counter is forwarded so back to back updates see it
  for (genvar t = 0; t < NumTables; t++) begin : g_tab
    localparam int D = 1 << idx_bits(t);
    localparam int AW = idx_bits(t);
    ctr_t mem [D];
    logic [AW-1:0] ra;
    assign ra = cmd_i.read ? hash[t][AW-1:0] : idx_q[t][AW-1:0];
    always_ff @(posedge clk_i) begin
      if (cmd_i.clear) mem[cmd_i.clr_addr[AW-1:0]] <= '0;
      else if (cmd_i.update && train) mem[idx_q[t][AW-1:0]] <= newc[t];
      if (cmd_i.update && train) rd_q[t] <= newc[t];
      else rd_q[t] <= mem[ra];
    end
  end

  always_comb begin
    sum = (SumW+2)'(NumTables / 2);
    for (int t = 0; t < NumTables; t++) sum = sum + (SumW+2)'(rd_q[t]);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int w = 0; w < HistWords; w++) ghist_q[w] <= '0;
      for (int t = 0; t < NumTables; t++) idx_q[t] <= '0;
      started_q <= 1'b0;
      path_q <= '0;
      last_sum_q <= '0;
      thr_q <= SumW'(8);
      tctr_q <= '0;
      out_valid_q <= 1'b0;
      out_sum_q <= '0;
    end else begin
      if (out_valid_q && out_ready_i && !cmd_i.sum) out_valid_q <= 1'b0;
      if (cmd_i.read) for (int t = 0; t < NumTables; t++) idx_q[t] <= hash[t];
      if (cmd_i.sum) begin
        last_sum_q <= sum[SumW-1:0];
        out_sum_q <= sum[SumW-1:0];
        out_valid_q <= 1'b1;
      end
      if (cmd_i.update) begin
        if (started_q) begin
          ghist_q[0] <= {ghist_q[0][WordBits-2:0], actual_taken_i};
          for (int w = 1; w < HistWords; w++)
            ghist_q[w] <= {ghist_q[w][WordBits-2:0], ghist_q[w-1][WordBits-1]};
        end
        started_q <= 1'b1;
        path_q <= {path_q[PathBits-4:0], 1'b0, pc_i[1:0]};
        if (miss) begin
          if (tctr_q >= ThrCtrW'(ThrCtrTop - 1)) begin
            tctr_q <= '0;
            if (thr_q < SumW'(255)) thr_q <= thr_q + 1'b1;
          end else tctr_q <= tctr_q + 1'b1;
        end else if (train) begin
          if (tctr_q <= ThrCtrW'(ThrCtrBot + 1)) begin
            tctr_q <= '0;
            thr_q <= thr_q - 1'b1;
          end else tctr_q <= tctr_q - 1'b1;
        end
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign confidence_sum_o = out_sum_q;
  assign predict_taken_o = !out_sum_q[SumW-1];
endmodule
`default_nettype wire

### design/geometric_history_sum_predictor.sv
// geometric history sum branch predictor
// one request channel (command, pc, actual_taken, predicted_taken) and one
// result channel (predict_taken, confidence_sum), both valid/ready.
// a predict request (command 0) reads eight counter tables at hashed indices
// and returns one result: the table read is registered, then the adder tree
// of the eight counters plus four is registered into the result.
// an update request (command 1) gives no result: it shifts global and path
// history, trains the counters at the stored indices and adapts the
// threshold.
// throughput: update every cycle unless a result is stalled; a predict
// holds off new requests until its sum step. after reset a clearing pass
// zeroes the tables, one entry per cycle; no request is accepted meanwhile.
// while a result waits on a stalled receiver, new requests are held off.
`timescale 1ns / 1ps
`default_nettype none
module geometric_history_sum_predictor (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_ready_o,
  input  logic command_i,
  input  logic [31:0] pc_i,
  input  logic actual_taken_i,
  input  logic predicted_taken_i,
  output logic out_valid_o,
  input  logic out_ready_i,
  output logic predict_taken_o,
  output logic signed [8:0] confidence_sum_o
);
  import ghsp_pkg::*;
  cmd_t cmd;

  // controller sequences clear, read and sum steps and issues updates
  // result register counts as free in the cycle it is taken
  ghsp_ctrl u_ctrl (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .command_i,
    .out_busy_i(out_valid_o && !out_ready_i), .cmd_o(cmd)
  );

  // datapath holds histories, tables and threshold logic
  ghsp_datapath u_dp (
    .clk_i, .rst_ni, .cmd_i(cmd), .pc_i, .actual_taken_i, .predicted_taken_i,
    .out_valid_o, .out_ready_i, .predict_taken_o, .confidence_sum_o
  );
endmodule
`default_nettype wire
